[design/modinv_pkg.sv]
// Shared types, constants and microcode ROM for the modular inverse core.
// No dependencies; every other design file imports this package.
`default_nettype none

package modinv_pkg;

	localparam int VALUE_WIDTH   = 63;
	localparam int MOD_WIDTH_DEF = 31;
	localparam int STEP_W        = 4;

	typedef logic [STEP_W-1:0] step_t;

	// Datapath operations issued by one control word
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_ALIGN,
		OP_SUB,
		OP_SWAP,
		OP_UPDATE,
		OP_FIN
	} uop_t;

	// Jump conditions; a true condition jumps to the target, else step advances
	typedef enum logic [2:0] {
		CND_NEXT,
		CND_ALWAYS,
		CND_NO_IN,
		CND_MOD_LT2,
		CND_CAN_SHIFT,
		CND_K_NZ,
		CND_RC_ZERO,
		CND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic in_valid;
		logic mod_lt2;
		logic can_shift;
		logic k_nz;
		logic rc_zero;
		logic out_busy;
	} dp_status_t;

	// Program steps
	localparam step_t ST_IDLE   = step_t'(0);
	localparam step_t ST_CHKM   = step_t'(1);
	localparam step_t ST_RALIGN = step_t'(2);
	localparam step_t ST_RSUB   = step_t'(3);
	localparam step_t ST_SWAP   = step_t'(4);
	localparam step_t ST_TEST   = step_t'(5);
	localparam step_t ST_EALIGN = step_t'(6);
	localparam step_t ST_ESUB   = step_t'(7);
	localparam step_t ST_UPDATE = step_t'(8);
	localparam step_t ST_FIN    = step_t'(9);
	localparam step_t ST_DONE   = step_t'(10);

	// Microcode ROM: reduce value mod m, then run extended Euclid
	function automatic uword_t ucode_rom(input step_t pc);
		uword_t w;
		case (pc)
			ST_IDLE:   w = '{OP_LOAD,   CND_NO_IN,     ST_IDLE};
			ST_CHKM:   w = '{OP_NOP,    CND_MOD_LT2,   ST_FIN};
			ST_RALIGN: w = '{OP_ALIGN,  CND_CAN_SHIFT, ST_RALIGN};
			ST_RSUB:   w = '{OP_SUB,    CND_K_NZ,      ST_RSUB};
			ST_SWAP:   w = '{OP_SWAP,   CND_NEXT,      ST_IDLE};
			ST_TEST:   w = '{OP_NOP,    CND_RC_ZERO,   ST_FIN};
			ST_EALIGN: w = '{OP_ALIGN,  CND_CAN_SHIFT, ST_EALIGN};
			ST_ESUB:   w = '{OP_SUB,    CND_K_NZ,      ST_ESUB};
			ST_UPDATE: w = '{OP_UPDATE, CND_ALWAYS,    ST_TEST};
			ST_FIN:    w = '{OP_FIN,    CND_OUT_BUSY,  ST_FIN};
			ST_DONE:   w = '{OP_NOP,    CND_ALWAYS,    ST_IDLE};
			default:   w = '{OP_NOP,    CND_ALWAYS,    ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[design/modinv_in_if.sv]
// Input channel interface: valid/ready handshake with value and modulus.
// Depends on modinv_pkg for default widths.
`default_nettype none

interface modinv_in_if
	import modinv_pkg::*;
#(
	parameter int MOD_WIDTH = MOD_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value_in;
	logic [MOD_WIDTH-1:0]   modulus;

	modport source (output valid, output value_in, output modulus, input ready);
	modport sink   (input valid, input value_in, input modulus, output ready);
endinterface

`default_nettype wire

[design/modinv_out_if.sv]
// Output channel interface: valid/ready handshake with inverse and flag.
// Depends on modinv_pkg for default widths.
`default_nettype none

interface modinv_out_if
	import modinv_pkg::*;
#(
	parameter int MOD_WIDTH = MOD_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic [MOD_WIDTH-1:0] inverse;
	logic                 has_inverse;

	modport source (output valid, output inverse, output has_inverse, input ready);
	modport sink   (input valid, input inverse, input has_inverse, output ready);
endinterface

`default_nettype wire

[design/modinv_seq.sv]
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on modinv_pkg for the ROM, control word and status types.
`default_nettype none

module modinv_seq
	import modinv_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_status_t status,
	output uop_t            op
);

	step_t  upc_q;
	step_t  upc_d;
	uword_t word;
	logic   taken;

	assign word = ucode_rom(upc_q);

	// Evaluate jump condition and pick next step
	always_comb begin
		case (word.cond)
			CND_NEXT:      taken = 1'b0;
			CND_ALWAYS:    taken = 1'b1;
			CND_NO_IN:     taken = !status.in_valid;
			CND_MOD_LT2:   taken = status.mod_lt2;
			CND_CAN_SHIFT: taken = status.can_shift;
			CND_K_NZ:      taken = status.k_nz;
			CND_RC_ZERO:   taken = status.rc_zero;
			CND_OUT_BUSY:  taken = status.out_busy;
			default:       taken = 1'b1;
		endcase
		upc_d = taken ? word.target : upc_q + step_t'(1);
	end

	// Drive datapath operation of the current step
	always_comb begin
		op = word.op;
	end

	// Advance step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

`default_nettype wire

[design/modinv_dp.sv]
// Datapath: shift-subtract divider with Horner quotient product, Bezout
// coefficients and output register. Depends on modinv_pkg.
`default_nettype none

module modinv_dp
	import modinv_pkg::*;
#(
	parameter int MOD_WIDTH = MOD_WIDTH_DEF
)(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire uop_t                   op,
	input  wire logic                   in_valid,
	input  wire logic [VALUE_WIDTH-1:0] value_in,
	input  wire logic [MOD_WIDTH-1:0]   modulus,
	input  wire logic                   out_ready,
	output dp_status_t                  status,
	output logic                        out_valid,
	output logic [MOD_WIDTH-1:0]        inverse,
	output logic                        has_inverse
);

	localparam int RW = VALUE_WIDTH;
	localparam int TW = MOD_WIDTH + 1;
	localparam int KW = $clog2(RW);

	logic [RW-1:0]        rp_q;
	logic [RW-1:0]        d_q;
	logic [MOD_WIDTH-1:0] rc_q;
	logic [MOD_WIDTH-1:0] m_q;
	logic [TW-1:0]        tp_q;
	logic [TW-1:0]        tc_q;
	logic [TW-1:0]        acc_q;
	logic [KW-1:0]        k_q;
	logic                 out_valid_q;
	logic [MOD_WIDTH-1:0] inverse_q;
	logic                 has_inverse_q;

	logic          can_shift;
	logic          ge;
	logic [RW-1:0] rp_diff;
	logic [TW-1:0] acc_next;
	logic [TW-1:0] t_new;
	logic [TW-1:0] t_fix;
	logic          mod_lt2;
	logic          ok;
	logic          out_busy;
	logic          load_fire;
	logic          fin_fire;

	// Compare, trial subtract and coefficient arithmetic
	always_comb begin
		can_shift = {d_q, 1'b0} <= {1'b0, rp_q};
		ge        = rp_q >= d_q;
		rp_diff   = rp_q - d_q;
		acc_next  = {acc_q[TW-2:0], 1'b0} + (ge ? tc_q : TW'(0));
		t_new     = tp_q - acc_q;
		t_fix     = tp_q + (tp_q[TW-1] ? TW'(m_q) : TW'(0));
		mod_lt2   = m_q < MOD_WIDTH'(2);
		ok        = (rp_q == RW'(1)) && !mod_lt2;
		out_busy  = out_valid_q && !out_ready;
		load_fire = (op == OP_LOAD) && in_valid;
		fin_fire  = (op == OP_FIN) && !out_busy;
	end

	// Report conditions to the sequencer
	always_comb begin
		status.in_valid  = in_valid;
		status.mod_lt2   = mod_lt2;
		status.can_shift = can_shift;
		status.k_nz      = k_q != KW'(0);
		status.rc_zero   = rc_q == MOD_WIDTH'(0);
		status.out_busy  = out_busy;
	end

	// Execute the current datapath operation
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				if (load_fire) begin
					rp_q <= value_in;
					m_q  <= modulus;
					rc_q <= modulus;
					d_q  <= RW'(modulus);
					k_q  <= KW'(0);
				end
			end
			OP_ALIGN: begin
				if (can_shift) begin
					d_q <= {d_q[RW-2:0], 1'b0};
					k_q <= k_q + KW'(1);
				end
			end
			OP_SUB: begin
				if (ge) begin
					rp_q <= rp_diff;
				end
				acc_q <= acc_next;
				d_q   <= {1'b0, d_q[RW-1:1]};
				if (k_q != KW'(0)) begin
					k_q <= k_q - KW'(1);
				end
			end
			OP_SWAP: begin
				rp_q  <= RW'(m_q);
				rc_q  <= rp_q[MOD_WIDTH-1:0];
				d_q   <= rp_q;
				tp_q  <= TW'(0);
				tc_q  <= TW'(1);
				acc_q <= TW'(0);
			end
			OP_UPDATE: begin
				rp_q  <= RW'(rc_q);
				rc_q  <= rp_q[MOD_WIDTH-1:0];
				d_q   <= rp_q;
				tp_q  <= tc_q;
				tc_q  <= t_new;
				acc_q <= TW'(0);
			end
			default: begin
			end
		endcase
	end

	// Hold the result word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			inverse_q     <= ok ? t_fix[MOD_WIDTH-1:0] : MOD_WIDTH'(0);
			has_inverse_q <= ok;
		end
	end

	assign out_valid   = out_valid_q;
	assign inverse     = inverse_q;
	assign has_inverse = has_inverse_q;

endmodule

`default_nettype wire

[design/modular_inverse_core.sv]
// Modular inverse by extended Euclid on one shared shift-subtract unit that
// yields one quotient bit per cycle. Latency is data dependent: the value is
// first reduced mod m by aligning and subtracting the divisor, then each Euclid
// step aligns, subtracts and updates the coefficients until the remainder is
// zero. One word at a time; the next word is taken in the idle step after the
// result is registered and the done step has passed. Reset clears the step
// counter and the output valid only.
`default_nettype none

module modular_inverse_core
	import modinv_pkg::*;
#(
	parameter int MOD_WIDTH = MOD_WIDTH_DEF
)(
	input  wire logic     clk,
	input  wire logic     arst_n,
	modinv_in_if.sink     in_ch,
	modinv_out_if.source  out_ch
);

	uop_t       op;
	dp_status_t status;

	// Take an input word only in the idle step
	assign in_ch.ready = (op == OP_LOAD);

	modinv_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op)
	);

	modinv_dp #(
		.MOD_WIDTH (MOD_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.in_valid    (in_ch.valid),
		.value_in    (in_ch.value_in),
		.modulus     (in_ch.modulus),
		.out_ready   (out_ch.ready),
		.status      (status),
		.out_valid   (out_ch.valid),
		.inverse     (out_ch.inverse),
		.has_inverse (out_ch.has_inverse)
	);

endmodule

`default_nettype wire
